[rtl/core/sccpad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SCCP address decoder package
// Shared types and constants for the SCCP party address decoder: register
// map, queue command format, result format and status codes.
// ----------------------------------------------------------------------------
package sccpad_pkg;

	// Configuration port geometry.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Register indexes (byte address is four times the index).
	localparam logic [1:0] REG_SSN_BEFORE_PC = 2'd0;
	localparam logic [1:0] REG_PC_BYTES      = 2'd1;
	localparam logic [1:0] REG_MAX_GT_LENGTH = 2'd2;

	// Register reset values.
	localparam logic       CFG_SSN_BEFORE_PC_RST = 1'b0;
	localparam logic [1:0] CFG_PC_BYTES_RST      = 2'd2;
	localparam logic [7:0] CFG_MAX_GT_LENGTH_RST = 8'd32;

	// Smallest point code size that is honored.
	localparam logic [1:0] PC_BYTES_MIN = 2'd2;

	// Default depth of the command queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic       ssn_before_pc;
		logic [1:0] pc_bytes;
		logic [7:0] max_gt_length;
	} cfg_t;

	// What the back end does with one word.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_START,
		OP_ERR,
		OP_PC,
		OP_SSN,
		OP_GT
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_NO_SSN   = 3'd2,
		ST_EMPTY_GT = 3'd3,
		ST_GT_LONG  = 3'd4
	} status_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [1:0] pc_idx;
		logic       last;
		status_t    status;
		logic [7:0] ind;
		logic [7:0] gt_len;
	} cmd_t;

	typedef struct packed {
		logic        gt_valid;
		logic [7:0]  gt_byte;
		logic        done_res;
		status_t     status;
		logic        pc_present;
		logic [23:0] point_code;
		logic        ssn_present;
		logic [7:0]  subsystem;
		logic [3:0]  gt_indicator;
		logic        ssn_routing;
		logic        national;
		logic [7:0]  gt_length;
	} result_t;

endpackage
`default_nettype wire

[rtl/core/sccp_address_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SCCP party address decoder
// Parses an SCCP party address one byte per word and reports the global
// title bytes and a summary of the address.
// ----------------------------------------------------------------------------
// The block takes one address byte per clock while the queue is not full,
// and gives exactly one result word per byte, in order. A byte is classified
// in the cycle it is accepted and enters the command queue at that edge;
// when nothing waits ahead of it and no stall holds the output register,
// its result word is loaded into the output register at the next edge.
// Sustained throughput is one byte per cycle when the output is not stalled.
// The queue of QUEUE_DEPTH words between the classifier and the result
// stage, with the output register, absorbs output stalls; the input stalls
// only when the queue is full. The last byte of an address gives done_res and
// the summary fields; an indicator failing a check gives done_res and status.
module sccp_address_decoder #(
	parameter int QUEUE_DEPTH = sccpad_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// Configuration port.
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [sccpad_pkg::PADDR_W-1:0] paddr,
	input  wire  [sccpad_pkg::PDATA_W-1:0] pwdata,
	output logic [sccpad_pkg::PDATA_W-1:0] prdata,
	output logic                           pready,
	// Input channel.
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [7:0]                     data_byte,
	input  wire                            first,
	// Output channel.
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic                           gt_valid,
	output logic [7:0]                     gt_byte,
	output logic                           done_res,
	output logic [2:0]                     status,
	output logic                           pc_present,
	output logic [23:0]                    point_code,
	output logic                           ssn_present,
	output logic [7:0]                     subsystem,
	output logic [3:0]                     gt_indicator,
	output logic                           ssn_routing,
	output logic                           national,
	output logic [7:0]                     gt_length
);
	import sccpad_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       cfg_wr;

	cmd_t    front_cmd;
	cmd_t    back_cmd;
	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_empty;
	result_t res;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ssn_before_pc <= CFG_SSN_BEFORE_PC_RST;
			cfg_q.pc_bytes      <= CFG_PC_BYTES_RST;
			cfg_q.max_gt_length <= CFG_MAX_GT_LENGTH_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SSN_BEFORE_PC: cfg_q.ssn_before_pc <= pwdata[0];
				REG_PC_BYTES:      cfg_q.pc_bytes      <= pwdata[1:0];
				REG_MAX_GT_LENGTH: cfg_q.max_gt_length <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Register readback.
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_SSN_BEFORE_PC: prdata = {{(PDATA_W-1){1'b0}}, cfg_q.ssn_before_pc};
			REG_PC_BYTES:      prdata = {{(PDATA_W-2){1'b0}}, cfg_q.pc_bytes};
			REG_MAX_GT_LENGTH: prdata = {{(PDATA_W-8){1'b0}}, cfg_q.max_gt_length};
			default:           prdata = '0;
		endcase
	end

	// Input handshake.
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	sccpad_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.data_byte (data_byte),
		.first     (first),
		.push      (push),
		.cmd       (front_cmd)
	);

	sccpad_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (front_cmd),
		.pop    (pop),
		.rd_cmd (back_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	sccpad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res       (res)
	);

	// Result fields.
	assign gt_valid     = res.gt_valid;
	assign gt_byte      = res.gt_byte;
	assign done_res     = res.done_res;
	assign status       = res.status;
	assign pc_present   = res.pc_present;
	assign point_code   = res.point_code;
	assign ssn_present  = res.ssn_present;
	assign subsystem    = res.subsystem;
	assign gt_indicator = res.gt_indicator;
	assign ssn_routing  = res.ssn_routing;
	assign national     = res.national;
	assign gt_length    = res.gt_length;

endmodule
`default_nettype wire

[rtl/core/sccpad_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SCCP address decoder front end
// Tracks the position inside the current address, checks the address
// indicator and turns every accepted byte into one command for the back end.
// ----------------------------------------------------------------------------
module sccpad_front (
	input  wire                clk,
	input  wire                arst_n,
	input  sccpad_pkg::cfg_t   cfg,
	input  wire  [7:0]         data_byte,
	input  wire                first,
	input  wire                push,
	output sccpad_pkg::cmd_t   cmd
);
	import sccpad_pkg::*;

	logic [7:0] pos_q;
	logic [7:0] len_q;
	logic [7:0] ind_q;
	logic [7:0] gt_len_q;
	logic       skip_q;

	logic [1:0] pcb;
	logic [2:0] ml;
	logic [7:0] gl;
	logic [3:0] gti;
	logic [7:0] gt_len_ind;
	status_t    ind_status;
	logic       sbp_ssn;
	logic [7:0] k0;
	logic [7:0] k1;
	logic [7:0] k2;

	// Point code size, with small values raised to the minimum.
	assign pcb = (cfg.pc_bytes < PC_BYTES_MIN) ? PC_BYTES_MIN : cfg.pc_bytes;

	// Indicator checks, evaluated on the incoming byte.
	assign gti = data_byte[5:2];
	assign ml  = 3'd1 + (data_byte[0] ? {1'b0, pcb} : 3'd0) + {2'b00, data_byte[1]};
	assign gl  = len_q - {5'b00000, ml};
	assign gt_len_ind = (gti != 4'd0) ? gl : 8'd0;

	always_comb begin
		ind_status = ST_OK;
		if ({5'b00000, ml} > len_q) begin
			ind_status = ST_SHORT;
		end else if (data_byte[6] && !data_byte[1]) begin
			ind_status = ST_NO_SSN;
		end else if (gti != 4'd0) begin
			if (gl == 8'd0) begin
				ind_status = ST_EMPTY_GT;
			end else if (gl >= cfg.max_gt_length) begin
				ind_status = ST_GT_LONG;
			end
		end
	end

	// Offsets into the optional fields, in the configured order.
	assign sbp_ssn = cfg.ssn_before_pc && ind_q[1];
	assign k0 = pos_q - 8'd2;
	assign k1 = sbp_ssn ? (k0 - 8'd1) : k0;
	assign k2 = ind_q[0] ? (k1 - {6'b000000, pcb}) : k1;

	// Classify the byte into a command.
	always_comb begin
		cmd        = '0;
		cmd.op     = OP_NONE;
		cmd.status = ST_OK;
		cmd.data   = data_byte;
		cmd.ind    = ind_q;
		cmd.gt_len = gt_len_q;
		if (first) begin
			cmd.op = OP_START;
		end else if (skip_q) begin
			cmd.op = OP_NONE;
		end else if (pos_q <= 8'd1) begin
			cmd.ind    = data_byte;
			cmd.gt_len = gt_len_ind;
			if (ind_status != ST_OK) begin
				cmd.op     = OP_ERR;
				cmd.status = ind_status;
			end else begin
				cmd.last = (len_q <= 8'd1);
			end
		end else begin
			cmd.last = (pos_q >= len_q);
			if (sbp_ssn && k0 == 8'd0) begin
				cmd.op = OP_SSN;
			end else if (ind_q[0] && k1 < {6'b000000, pcb}) begin
				cmd.op     = OP_PC;
				cmd.pc_idx = k1[1:0];
			end else if (!cfg.ssn_before_pc && ind_q[1] && k2 == 8'd0) begin
				cmd.op = OP_SSN;
			end else if (ind_q[5:2] != 4'd0) begin
				cmd.op = OP_GT;
			end
		end
	end

	// Address position state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			ind_q    <= '0;
			gt_len_q <= '0;
			skip_q   <= 1'b1;
		end else if (push) begin
			if (first) begin
				len_q  <= data_byte;
				pos_q  <= 8'd1;
				ind_q  <= '0;
				skip_q <= 1'b0;
			end else if (!skip_q) begin
				if (pos_q <= 8'd1) begin
					ind_q    <= data_byte;
					gt_len_q <= gt_len_ind;
					if (ind_status != ST_OK || len_q <= 8'd1) begin
						skip_q <= 1'b1;
					end else begin
						pos_q <= 8'd2;
					end
				end else if (pos_q >= len_q) begin
					skip_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 8'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/sccpad_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SCCP address decoder command queue
// A small first-in first-out queue of commands between the front end and
// the back end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module sccpad_queue #(
	parameter int DEPTH = sccpad_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  sccpad_pkg::cmd_t   wr_cmd,
	input  wire                pop,
	output sccpad_pkg::cmd_t   rd_cmd,
	output logic               full,
	output logic               empty
);
	import sccpad_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == FULL_CNT);
	assign empty  = (count_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/sccpad_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SCCP address decoder back end
// Carries out queued commands: collects the point code and subsystem,
// passes global title bytes and builds the result in the output register.
// ----------------------------------------------------------------------------
module sccpad_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sccpad_pkg::cmd_t    cmd,
	input  wire                 q_empty,
	output logic                pop,
	input  wire                 out_stall,
	output logic                out_valid,
	output sccpad_pkg::result_t res
);
	import sccpad_pkg::*;

	logic [23:0] pc_acc_q;
	logic [7:0]  ssn_q;
	logic        out_valid_q;
	result_t     res_q;

	logic [23:0] pc_acc_nx;
	logic [7:0]  ssn_nx;
	result_t     res_nx;

	assign pop       = !q_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// Next values of the collected fields.
	always_comb begin
		pc_acc_nx = pc_acc_q;
		ssn_nx    = ssn_q;
		case (cmd.op)
			OP_START: begin
				pc_acc_nx = '0;
				ssn_nx    = '0;
			end
			OP_PC: begin
				pc_acc_nx = pc_acc_q | ({16'h0000, cmd.data} << {cmd.pc_idx, 3'b000});
			end
			OP_SSN: begin
				ssn_nx = cmd.data;
			end
			default: begin
			end
		endcase
	end

	// Result word for this command.
	always_comb begin
		res_nx        = '0;
		res_nx.status = ST_OK;
		if (cmd.op == OP_ERR) begin
			res_nx.done_res = 1'b1;
			res_nx.status   = cmd.status;
		end
		if (cmd.op == OP_GT) begin
			res_nx.gt_valid = 1'b1;
			res_nx.gt_byte  = cmd.data;
		end
		if (cmd.last) begin
			res_nx.done_res     = 1'b1;
			res_nx.pc_present   = cmd.ind[0];
			res_nx.point_code   = cmd.ind[0] ? pc_acc_nx : 24'h000000;
			res_nx.ssn_present  = cmd.ind[1];
			res_nx.subsystem    = cmd.ind[1] ? ssn_nx : 8'h00;
			res_nx.gt_indicator = cmd.ind[5:2];
			res_nx.ssn_routing  = cmd.ind[6];
			res_nx.national     = cmd.ind[7];
			res_nx.gt_length    = cmd.gt_len;
		end
	end

	// Collected fields and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_acc_q    <= '0;
			ssn_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pc_acc_q    <= pc_acc_nx;
				ssn_q       <= ssn_nx;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_nx;
		end
	end

endmodule
`default_nettype wire

[rtl/core/sccpad_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SCCP address decoder checker
// Port-level checks on the result channel of the address decoder, bound to
// the top level.
// ----------------------------------------------------------------------------
module sccpad_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire        gt_valid,
	input wire [7:0]  gt_byte,
	input wire        done_res,
	input wire [2:0]  status,
	input wire        pc_present,
	input wire [23:0] point_code,
	input wire        ssn_present,
	input wire [7:0]  subsystem,
	input wire [7:0]  gt_length
);
	import sccpad_pkg::*;

	// A stalled word stays and keeps its summary.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(done_res) && $stable(point_code)
			&& $stable(gt_byte))
		else $error("result word changed while stalled");

	// A word that does not end an address carries no summary.
	a_no_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == ST_OK && point_code == 24'd0
			&& subsystem == 8'd0 && gt_length == 8'd0)
		else $error("summary fields set without done_res");

	// An error result has gt_valid, pc_present, ssn_present, point_code and gt_length clear.
	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res && status != ST_OK |-> !gt_valid && !pc_present
			&& !ssn_present && point_code == 24'd0 && gt_length == 8'd0)
		else $error("error result carries address fields");

	// Absent parts read as zero.
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pc_present || point_code == 24'd0)
			&& (ssn_present || subsystem == 8'd0) && (gt_valid || gt_byte == 8'd0))
		else $error("absent field is not zero");

endmodule

bind sccp_address_decoder sccpad_checker u_sccpad_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.gt_valid    (gt_valid),
	.gt_byte     (gt_byte),
	.done_res    (done_res),
	.status      (status),
	.pc_present  (pc_present),
	.point_code  (point_code),
	.ssn_present (ssn_present),
	.subsystem   (subsystem),
	.gt_length   (gt_length)
);
`default_nettype wire
